/* sv/nps_pkg.sv */
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and codes for the 3d nearest point search block.
// ----------------------------------------------------------------------------
package nps_pkg;

   // field widths fixed by the word formats
   localparam int INDEX_W = 6;
   localparam int COORD_W = 16;
   localparam int SQ_W    = 32;
   localparam int DIST_W  = 34;

   // operation codes
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_SET   = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_BAD_INDEX = 2'd2;
   localparam logic [1:0] ST_ALONE     = 2'd3;

   // request word
   typedef struct packed {
      logic [1:0]                operation;
      logic [INDEX_W-1:0]        entry_index;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
   } req_type;

   // response word
   typedef struct packed {
      logic [1:0]         status;
      logic [INDEX_W-1:0] result_index;
      logic [DIST_W-1:0]  nearest_dist_sq;
   } rsp_type;

endpackage

/* sv/nps_ram.sv */
// ----------------------------------------------------------------------------
// nps_ram
// Simple dual port ram: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nps_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

/* sv/nearest_point_search_3d.sv */
// ----------------------------------------------------------------------------
// nearest_point_search_3d
// Point table in signed q8.8 with add, move and brute force nearest query.
// Add, set, bad requests: accept moves to finish, which raises the response once
// the output is free and then is ready again. Query: a scan reads one table
// entry per cycle through the single ram read port into the distance pipeline.
// Reset (synchronous) empties the table; stored points stay unknown until added.
// ----------------------------------------------------------------------------
module nearest_point_search_3d #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  nps_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nps_pkg::rsp_type rsp_word
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int XW = (CW > nps_pkg::INDEX_W) ? CW : nps_pkg::INDEX_W;
   localparam int PW = 3 * nps_pkg::COORD_W;

   typedef struct packed {
      logic signed [nps_pkg::COORD_W-1:0] x;
      logic signed [nps_pkg::COORD_W-1:0] y;
      logic signed [nps_pkg::COORD_W-1:0] z;
   } point_type;

   typedef enum logic [1:0] {S_IDLE, S_SOURCE, S_SCAN, S_FINISH} state_type;

   // absolute difference of two signed coordinates
   function automatic logic [nps_pkg::COORD_W-1:0] abs_diff(
      input logic signed [nps_pkg::COORD_W-1:0] a,
      input logic signed [nps_pkg::COORD_W-1:0] b
   );
      logic signed [nps_pkg::COORD_W:0] d;
      d = (nps_pkg::COORD_W+1)'(a) - (nps_pkg::COORD_W+1)'(b);
      return d[nps_pkg::COORD_W] ? nps_pkg::COORD_W'(-d) : d[nps_pkg::COORD_W-1:0];
   endfunction

   // control registers
   state_type                   state_ff, state_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               scan_ff, scan_in;
   logic                        found_ff, found_in;
   logic                        rd_vld_ff, rd_vld_in;
   logic                        d_vld_ff, d_vld_in;
   logic                        q_vld_ff, q_vld_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [AW-1:0]               src_idx_ff, src_idx_in;
   point_type                   src_ff, src_in;
   logic [AW-1:0]               rd_idx_ff, rd_idx_in;
   logic [AW-1:0]               d_idx_ff, d_idx_in;
   logic [AW-1:0]               q_idx_ff, q_idx_in;
   logic [nps_pkg::COORD_W-1:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [nps_pkg::SQ_W-1:0]    sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic [nps_pkg::DIST_W-1:0]  best_dist_ff, best_dist_in;
   logic [AW-1:0]               best_idx_ff, best_idx_in;
   nps_pkg::rsp_type            res_ff, res_in;
   nps_pkg::rsp_type            rsp_word_ff, rsp_word_in;

   // ram side
   logic                        ram_we;
   logic [AW-1:0]               ram_waddr;
   point_type                   ram_wdata;
   logic [AW-1:0]               ram_raddr;
   point_type                   ram_rdata;

   logic                        accept;
   logic                        issue;
   logic                        pipe_empty;
   logic                        rsp_free;
   logic [XW-1:0]               idx_ext;
   logic [XW-1:0]               count_ext;
   logic [nps_pkg::DIST_W-1:0]  dist_sum;

   // point table
   nps_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // handshake and shared terms
   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign idx_ext    = XW'(req_word.entry_index);
   assign count_ext  = XW'(count_ff);
   assign issue      = ((state_ff == S_SOURCE) || (state_ff == S_SCAN))
                     && (scan_ff != count_ff);
   assign pipe_empty = !rd_vld_ff && !d_vld_ff && !q_vld_ff;
   assign ram_raddr  = (state_ff == S_IDLE) ? AW'(idx_ext) : AW'(scan_ff);
   assign dist_sum   = nps_pkg::DIST_W'(sx_ff) + nps_pkg::DIST_W'(sy_ff)
                     + nps_pkg::DIST_W'(sz_ff);

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      found_in     = found_ff;
      src_idx_in   = src_idx_ff;
      src_in       = src_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      res_in       = res_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_we       = 1'b0;
      ram_waddr    = AW'(count_ff);
      ram_wdata    = '{x: req_word.coord_x, y: req_word.coord_y, z: req_word.coord_z};

      // scan issue: one table read per cycle
      rd_vld_in = issue;
      rd_idx_in = AW'(scan_ff);
      if (issue) begin
         scan_in = scan_ff + 1'b1;
      end

      // distance stage: the source entry itself is dropped
      d_vld_in = rd_vld_ff && (rd_idx_ff != src_idx_ff);
      d_idx_in = rd_idx_ff;
      dx_in    = abs_diff(ram_rdata.x, src_ff.x);
      dy_in    = abs_diff(ram_rdata.y, src_ff.y);
      dz_in    = abs_diff(ram_rdata.z, src_ff.z);

      // square stage
      q_vld_in = d_vld_ff;
      q_idx_in = d_idx_ff;
      sx_in    = dx_ff * dx_ff;
      sy_in    = dy_ff * dy_ff;
      sz_in    = dz_ff * dz_ff;

      // sum and strict compare, lowest index wins ties
      if (q_vld_ff && (!found_ff || (dist_sum < best_dist_ff))) begin
         found_in     = 1'b1;
         best_dist_in = dist_sum;
         best_idx_in  = q_idx_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               found_in   = 1'b0;
               scan_in    = '0;
               src_idx_in = AW'(idx_ext);
               res_in     = '0;
               res_in.status = nps_pkg::ST_OK;
               state_in   = S_FINISH;
               case (req_word.operation)
                  nps_pkg::OP_ADD: begin
                     if (count_ff == CW'(MAX_ENTRIES)) begin
                        res_in.status = nps_pkg::ST_FULL;
                     end else begin
                        ram_we              = 1'b1;
                        ram_waddr           = AW'(count_ff);
                        res_in.result_index = nps_pkg::INDEX_W'(count_ff);
                        count_in            = count_ff + 1'b1;
                     end
                  end
                  nps_pkg::OP_SET: begin
                     if (idx_ext >= count_ext) begin
                        res_in.status = nps_pkg::ST_BAD_INDEX;
                     end else begin
                        ram_we              = 1'b1;
                        ram_waddr           = AW'(idx_ext);
                        res_in.result_index = req_word.entry_index;
                     end
                  end
                  nps_pkg::OP_QUERY: begin
                     if (count_ff < CW'(2)) begin
                        res_in.status = nps_pkg::ST_ALONE;
                     end else if (idx_ext >= count_ext) begin
                        res_in.status = nps_pkg::ST_BAD_INDEX;
                     end else begin
                        state_in = S_SOURCE;
                     end
                  end
                  default: begin
                     res_in.status = nps_pkg::ST_OK;
                  end
               endcase
            end
         end
         S_SOURCE: begin
            // source point arrives from the read issued at accept
            src_in   = ram_rdata;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if ((scan_ff == count_ff) && pipe_empty) begin
               res_in.status          = nps_pkg::ST_OK;
               res_in.result_index    = nps_pkg::INDEX_W'(best_idx_ff);
               res_in.nearest_dist_sq = best_dist_ff;
               state_in               = S_FINISH;
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_word_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         d_vld_ff     <= 1'b0;
         q_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_word_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         rd_vld_ff    <= rd_vld_in;
         d_vld_ff     <= d_vld_in;
         q_vld_ff     <= q_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_word_ff  <= rsp_word_in;
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      src_idx_ff   <= src_idx_in;
      src_ff       <= src_in;
      rd_idx_ff    <= rd_idx_in;
      d_idx_ff     <= d_idx_in;
      q_idx_ff     <= q_idx_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      dz_ff        <= dz_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      sz_ff        <= sz_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      res_ff       <= res_in;
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count above table size");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH))
      else $error("response word raised outside finish");

   a_compare_in_scan: assert property (@(posedge clock) disable iff (reset)
      q_vld_ff |-> (state_ff == S_SCAN))
      else $error("distance compare outside scan");

   a_scan_found: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SCAN) && (scan_ff == count_ff) && pipe_empty) |-> found_ff)
      else $error("query scan ended without a neighbor");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff)))
         |-> ((count_ff == $past(count_ff) + 1'b1) && ($past(state_ff) == S_IDLE)))
      else $error("entry count moved other than by one add");

endmodule

/* tb/tb_nearest_point_search_3d.sv */
// ----------------------------------------------------------------------------
// tb_nearest_point_search_3d
// Self-checking bench for the 3d nearest point search block. A fixed table of
// requests covers the alone and bad index statuses, the extreme coordinates and tie breaks.
// After it come three random phases with different back pressure. Every
// response is compared, field by field, with the fixed response of its row or
// with a local model of the point table and its brute force search.
// ----------------------------------------------------------------------------
module tb_nearest_point_search_3d;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 64;
   localparam int PHASE_WORDS = 160;
   localparam int LONG_HOLD   = 400;
   localparam int DRAIN_TAIL  = 80;

   // opcode with no function, answered with an all-zero ok word
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [nps_pkg::COORD_W-1:0] C_MIN  = 16'h8000;
   localparam logic [nps_pkg::COORD_W-1:0] C_MAX  = 16'h7FFF;
   localparam logic [nps_pkg::COORD_W-1:0] C_ZERO = 16'h0000;
   localparam logic [nps_pkg::COORD_W-1:0] C_ONE  = 16'h0100;
   localparam logic [nps_pkg::COORD_W-1:0] C_NEG1 = 16'hFF00;

   // one row of the directed table; fixed rows carry their own response
   typedef struct packed {
      nps_pkg::req_type word;
      logic             fixed;
      nps_pkg::rsp_type rsp;
   } plan_row_type;

   localparam plan_row_type PLAN [24] = '{
      // empty table
      '{'{nps_pkg::OP_QUERY, 6'd0, C_ZERO, C_ZERO, C_ZERO}, 1'b1,
        '{nps_pkg::ST_ALONE, 6'd0, 34'd0}},
      '{'{nps_pkg::OP_SET, 6'd0, C_ONE, C_ONE, C_ONE}, 1'b1,
        '{nps_pkg::ST_BAD_INDEX, 6'd0, 34'd0}},
      '{'{OP_UNUSED, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
        '{nps_pkg::ST_OK, 6'd0, 34'd0}},
      // corners of the coordinate range
      '{'{nps_pkg::OP_ADD, 6'd0, C_MIN, C_MIN, C_MIN}, 1'b1,
        '{nps_pkg::ST_OK, 6'd0, 34'd0}},
      '{'{nps_pkg::OP_QUERY, 6'd0, C_ZERO, C_ZERO, C_ZERO}, 1'b1,
        '{nps_pkg::ST_ALONE, 6'd0, 34'd0}},
      '{'{nps_pkg::OP_ADD, 6'd0, C_MAX, C_MAX, C_MAX}, 1'b1,
        '{nps_pkg::ST_OK, 6'd1, 34'd0}},
      '{'{nps_pkg::OP_QUERY, 6'd0, C_ZERO, C_ZERO, C_ZERO}, 1'b1,
        '{nps_pkg::ST_OK, 6'd1, 34'd12884508675}},
      '{'{nps_pkg::OP_QUERY, 6'd1, C_ZERO, C_ZERO, C_ZERO}, 1'b1,
        '{nps_pkg::ST_OK, 6'd0, 34'd12884508675}},
      '{'{nps_pkg::OP_QUERY, 6'd2, C_ZERO, C_ZERO, C_ZERO}, 1'b1,
        '{nps_pkg::ST_BAD_INDEX, 6'd0, 34'd0}},
      '{'{nps_pkg::OP_QUERY, 6'd63, C_ZERO, C_ZERO, C_ZERO}, 1'b1,
        '{nps_pkg::ST_BAD_INDEX, 6'd0, 34'd0}},
      // equal distances, lowest slot must win
      '{'{nps_pkg::OP_ADD, 6'd0, C_ZERO, C_ZERO, C_ZERO}, 1'b1,
        '{nps_pkg::ST_OK, 6'd2, 34'd0}},
      '{'{nps_pkg::OP_ADD, 6'd0, C_ONE, C_ZERO, C_ZERO}, 1'b1,
        '{nps_pkg::ST_OK, 6'd3, 34'd0}},
      '{'{nps_pkg::OP_ADD, 6'd0, C_NEG1, C_ZERO, C_ZERO}, 1'b1,
        '{nps_pkg::ST_OK, 6'd4, 34'd0}},
      '{'{nps_pkg::OP_QUERY, 6'd2, C_ZERO, C_ZERO, C_ZERO}, 1'b0, '0},
      '{'{nps_pkg::OP_SET, 6'd4, C_ZERO, C_ZERO, C_ZERO}, 1'b1,
        '{nps_pkg::ST_OK, 6'd4, 34'd0}},
      '{'{nps_pkg::OP_QUERY, 6'd2, C_ZERO, C_ZERO, C_ZERO}, 1'b0, '0},
      '{'{nps_pkg::OP_SET, 6'd5, C_ZERO, C_ZERO, C_ZERO}, 1'b1,
        '{nps_pkg::ST_BAD_INDEX, 6'd0, 34'd0}},
      '{'{nps_pkg::OP_SET, 6'd0, C_MAX, C_MIN, 16'h0001}, 1'b1,
        '{nps_pkg::ST_OK, 6'd0, 34'd0}},
      '{'{nps_pkg::OP_QUERY, 6'd0, C_ZERO, C_ZERO, C_ZERO}, 1'b0, '0},
      '{'{OP_UNUSED, 6'd0, C_ZERO, C_ZERO, C_ZERO}, 1'b1,
        '{nps_pkg::ST_OK, 6'd0, 34'd0}},
      '{'{nps_pkg::OP_QUERY, 6'd4, C_ZERO, C_ZERO, C_ZERO}, 1'b0, '0},
      // add ignores the index field
      '{'{nps_pkg::OP_ADD, 6'd63, 16'h1234, 16'hEDCC, 16'h00FF}, 1'b1,
        '{nps_pkg::ST_OK, 6'd5, 34'd0}},
      '{'{nps_pkg::OP_QUERY, 6'd5, C_ZERO, C_ZERO, C_ZERO}, 1'b0, '0},
      '{'{nps_pkg::OP_QUERY, 6'd3, C_ZERO, C_ZERO, C_ZERO}, 1'b0, '0}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   nps_pkg::req_type req_word = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   nps_pkg::rsp_type rsp_word;

   // local copy of the point table
   logic signed [nps_pkg::COORD_W-1:0] stored_x [TABLE_DEPTH];
   logic signed [nps_pkg::COORD_W-1:0] stored_y [TABLE_DEPTH];
   logic signed [nps_pkg::COORD_W-1:0] stored_z [TABLE_DEPTH];
   int unsigned                        filled = 0;

   nps_pkg::rsp_type pending_rsp_q [$];
   int               fail_count = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   bit               hold_rsp_request = 1'b0;

   nearest_point_search_3d #(
      .MAX_ENTRIES(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // squared difference along one axis, exact
   function automatic longint unsigned axis_sq(
      input logic signed [nps_pkg::COORD_W-1:0] a,
      input logic signed [nps_pkg::COORD_W-1:0] b
   );
      longint diff;
      diff = longint'(a) - longint'(b);
      return diff * diff;
   endfunction

   // apply one request to the local table and return the response it earns
   function automatic nps_pkg::rsp_type predict_search(input nps_pkg::req_type w);
      nps_pkg::rsp_type  r;
      longint unsigned   d;
      longint unsigned   best_d;
      int unsigned       i;
      int unsigned       src;
      int unsigned       best;
      logic              found;
      r = '0;
      best = 0;
      best_d = 0;
      found = 1'b0;
      src = 32'(w.entry_index);
      case (w.operation)
         nps_pkg::OP_ADD: begin
            if (filled >= TABLE_DEPTH) begin
               r.status = nps_pkg::ST_FULL;
            end else begin
               stored_x[filled] = w.coord_x;
               stored_y[filled] = w.coord_y;
               stored_z[filled] = w.coord_z;
               r.result_index = nps_pkg::INDEX_W'(filled);
               filled++;
            end
         end
         nps_pkg::OP_SET: begin
            if (src >= filled) begin
               r.status = nps_pkg::ST_BAD_INDEX;
            end else begin
               stored_x[src] = w.coord_x;
               stored_y[src] = w.coord_y;
               stored_z[src] = w.coord_z;
               r.result_index = w.entry_index;
            end
         end
         nps_pkg::OP_QUERY: begin
            if (filled < 2) begin
               r.status = nps_pkg::ST_ALONE;
            end else if (src >= filled) begin
               r.status = nps_pkg::ST_BAD_INDEX;
            end else begin
               // strict compare keeps the lowest slot on a tie
               for (i = 0; i < filled; i++) begin
                  if (i != src) begin
                     d = axis_sq(stored_x[i], stored_x[src])
                       + axis_sq(stored_y[i], stored_y[src])
                       + axis_sq(stored_z[i], stored_z[src]);
                     if (!found || d < best_d) begin
                        found = 1'b1;
                        best = i;
                        best_d = d;
                     end
                  end
               end
               r.result_index = nps_pkg::INDEX_W'(best);
               r.nearest_dist_sq = best_d[nps_pkg::DIST_W-1:0];
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // coordinate mix: full range, tight cluster for ties, corners, whole units
   function automatic logic signed [nps_pkg::COORD_W-1:0] random_coord();
      int unsigned pick;
      int          v;
      pick = $urandom_range(99);
      if (pick < 40) begin
         return nps_pkg::COORD_W'($urandom);
      end else if (pick < 75) begin
         v = int'($urandom_range(8)) - 4;
         return nps_pkg::COORD_W'(v);
      end else if (pick < 85) begin
         case ($urandom_range(3))
            0: return C_MIN;
            1: return C_MAX;
            2: return 16'hFFFF;
            default: return C_ZERO;
         endcase
      end
      v = (int'($urandom_range(16)) - 8) * 256;
      return nps_pkg::COORD_W'(v);
   endfunction

   // mostly valid indexes, some anywhere in the field
   function automatic nps_pkg::req_type random_request();
      nps_pkg::req_type w;
      int unsigned      pick;
      pick = $urandom_range(99);
      if (pick < 22) begin
         w.operation = nps_pkg::OP_ADD;
      end else if (pick < 50) begin
         w.operation = nps_pkg::OP_SET;
      end else if (pick < 95) begin
         w.operation = nps_pkg::OP_QUERY;
      end else begin
         w.operation = OP_UNUSED;
      end
      if (filled != 0 && $urandom_range(9) != 0) begin
         w.entry_index = nps_pkg::INDEX_W'($urandom_range(filled - 1));
      end else begin
         w.entry_index = nps_pkg::INDEX_W'($urandom_range(63));
      end
      w.coord_x = random_coord();
      w.coord_y = random_coord();
      w.coord_z = random_coord();
      return w;
   endfunction

   // offer one word, starting and ending at a falling edge
   task automatic send_word(input nps_pkg::req_type w, input logic fixed,
                            input nps_pkg::rsp_type fixed_rsp);
      nps_pkg::rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_search(w);
      if (fixed) begin
         predicted = fixed_rsp;
      end
      pending_rsp_q.insert(pending_rsp_q.size(), predicted);
      @(negedge clock);
   endtask

   // sender goes quiet until every response is back
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_rsp_q.size() != 0) @(negedge clock);
   endtask

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // receiver: random ready, with one long hold on request
   initial begin : rsp_side
      forever begin
         @(negedge clock);
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each accepted response with the oldest expectation
   always @(posedge clock) begin : rsp_check
      nps_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp_q.size() == 0) begin
            $error("response word %h with nothing expected", rsp_word);
            fail_count++;
         end else begin
            want = pending_rsp_q.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_word.status));
            check_field("result_index", 64'(want.result_index),
                        64'(rsp_word.result_index));
            check_field("nearest_dist_sq", 64'(want.nearest_dist_sq),
                        64'(rsp_word.nearest_dist_sq));
         end
      end
   end

   initial begin : stimulus
      int phase;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      send_idle_pct = 37;
      recv_idle_pct = 54;
      foreach (PLAN[i]) begin
         send_word(PLAN[i].word, PLAN[i].fixed, PLAN[i].rsp);
      end
      drain();

      // random phases: receiver idles more, then sender idles more, then no random idling but one long hold
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 37;
               recv_idle_pct = 54;
            end
            1: begin
               send_idle_pct = 54;
               recv_idle_pct = 37;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               hold_rsp_request = 1'b1;
            end
         endcase
         repeat (PHASE_WORDS) send_word(random_request(), 1'b0, '0);
         drain();
      end

      repeat (DRAIN_TAIL) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : watchdog
      #3_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* nearest_point_search_3d.f */
sv/nps_pkg.sv
sv/nps_ram.sv
sv/nearest_point_search_3d.sv
tb/tb_nearest_point_search_3d.sv
